// ===== src/sbs_pkg.sv =====
// Shared types and constants for the scanline Bresenham span generator.
// No dependencies; imported by sbs_step and scanline_bresenham_span.
package sbs_pkg;

  localparam int unsigned CoordBitsDef = 10;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIFF = 5'b00010,
    ST_INIT = 5'b00100,
    ST_WALK = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    MODE_SHALLOW     = 2'd0,
    MODE_STEEP_RIGHT = 2'd1,
    MODE_STEEP_LEFT  = 2'd2
  } mode_e;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_NEXT  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic always_move;  // shallow: x moves every step
    logic left;         // x steps toward lower values
  } step_ctl_t;

endpackage

// ===== src/scanline_bresenham_span.sv =====
// Top level of the scanline Bresenham span generator: request handshake,
// line setup sequencer and span walk. Depends on sbs_pkg and sbs_step.
//
// A request with tuser 0 starts a line from two endpoints and answers with a
// not-valid result after the DIFF and INIT setup states. A request with
// tuser 1 returns the leftmost and rightmost x of the line on the next
// scanline: a steep line returns its current x as both ends, a shallow line
// walks the run, the pixels on that scanline, through the error-term adder,
// which steps one x per cycle. A request on an ended line answers not valid.
// The block takes one request at a time; its result register lets the next
// request in while a result waits.
module scanline_bresenham_span import sbs_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef,
  localparam int unsigned InW  = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OutW = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [InW-1:0]  s_axis_tdata,  // start_x, start_y, end_x, end_y
  input  logic            s_axis_tuser,  // command
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [OutW-1:0] m_axis_tdata,  // left_x, right_x
  output logic            m_axis_tuser   // span_valid
);

  localparam int unsigned C  = COORD_BITS;
  localparam int unsigned EW = C + 3;
  localparam int unsigned XW = C + 2;

  state_e state_q, state_d;

  logic [C-1:0] in_sx, in_sy, in_ex, in_ey;
  logic         accept;

  logic [C-1:0] x0_q, x1_q, y0_q, y1_q;
  logic signed [C:0] dx_q;
  logic [C-1:0] ady_q;

  mode_e                mode_q;
  logic signed [EW-1:0] err_q;
  logic signed [EW-1:0] diag_q;
  logic [C:0]           str_q;
  logic [C-1:0]         cur_q;
  logic [C-1:0]         lim_q;
  logic                 active_q;

  logic signed [XW-1:0] h_q;
  logic [C-1:0]         edge_x_q;
  logic                 left_q;

  logic         res_valid_q;
  logic [C-1:0] res_l_q, res_r_q;

  logic         mo_valid_q, mo_user_q;
  logic [C-1:0] mo_l_q, mo_r_q;

  step_ctl_t            step_ctl;
  logic signed [EW-1:0] step_err;
  logic signed [XW-1:0] step_h;
  logic                 step_pos;

  logic [C-1:0] adx, major, minor;
  logic         shallow_gt;
  logic signed [XW-1:0] lim_s, h_m1, h_p1;
  logic         past_end, walk_fin;
  logic         out_load;

  assign in_sx = s_axis_tdata[C-1:0];
  assign in_sy = s_axis_tdata[2*C-1:C];
  assign in_ex = s_axis_tdata[3*C-1:2*C];
  assign in_ey = s_axis_tdata[4*C-1:3*C];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;

  assign adx        = dx_q[C] ? C'(-dx_q) : dx_q[C-1:0];
  assign shallow_gt = (adx > ady_q);
  assign major      = shallow_gt ? adx : ady_q;
  assign minor      = shallow_gt ? ady_q : adx;

  assign step_ctl.always_move = (mode_q == MODE_SHALLOW);
  assign step_ctl.left        = left_q;

  sbs_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .err_i (err_q),
    .diag_i(diag_q),
    .str_i (str_q),
    .h_i   (h_q),
    .ctl_i (step_ctl),
    .err_o (step_err),
    .h_o   (step_h),
    .pos_o (step_pos)
  );

  assign lim_s    = $signed({2'b00, lim_q});
  assign past_end = left_q ? (step_h < lim_s) : (step_h > lim_s);
  assign walk_fin = step_pos | past_end;
  assign h_m1     = step_h - $signed(XW'(1));
  assign h_p1     = step_h + $signed(XW'(1));

  assign out_load = (state_q == ST_DONE) & (~mo_valid_q | m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == CMD_START) begin
            state_d = ST_DIFF;
          end else if (!active_q) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_DIFF: state_d = ST_INIT;
      ST_INIT: state_d = ST_DONE;
      ST_WALK: begin
        if (mode_q != MODE_SHALLOW || walk_fin) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_SHALLOW;
      err_q       <= '0;
      diag_q      <= '0;
      str_q       <= '0;
      cur_q       <= '0;
      lim_q       <= '0;
      active_q    <= 1'b0;
      res_valid_q <= 1'b0;
      mo_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (accept && s_axis_tuser == CMD_NEXT) begin
            res_valid_q <= active_q;
          end
        end
        ST_INIT: begin
          err_q       <= $signed(EW'({minor, 1'b0})) - $signed(EW'(major));
          diag_q      <= ($signed(EW'(minor)) - $signed(EW'(major))) <<< 1;
          str_q       <= {minor, 1'b0};
          cur_q       <= x0_q;
          lim_q       <= shallow_gt ? x1_q : ady_q;
          active_q    <= 1'b1;
          res_valid_q <= 1'b0;
          if (shallow_gt) begin
            mode_q <= MODE_SHALLOW;
          end else if (dx_q[C]) begin
            mode_q <= MODE_STEEP_LEFT;
          end else begin
            mode_q <= MODE_STEEP_RIGHT;
          end
        end
        ST_WALK: begin
          err_q <= step_err;
          if (mode_q != MODE_SHALLOW) begin
            cur_q <= step_h[C-1:0];
            lim_q <= lim_q - C'(1);
            if (lim_q == '0) begin
              active_q <= 1'b0;
            end
          end else if (walk_fin) begin
            cur_q <= step_h[C-1:0];
            if (past_end) begin
              active_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (out_load) begin
        mo_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        mo_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_l_q <= '0;
          res_r_q <= '0;
          if (in_sy > in_ey) begin
            x0_q <= in_ex;
            y0_q <= in_ey;
            x1_q <= in_sx;
            y1_q <= in_sy;
          end else begin
            x0_q <= in_sx;
            y0_q <= in_sy;
            x1_q <= in_ex;
            y1_q <= in_ey;
          end
          h_q      <= $signed({2'b00, cur_q});
          edge_x_q <= cur_q;
          if (mode_q == MODE_SHALLOW) begin
            left_q <= ~(cur_q < lim_q);
          end else begin
            left_q <= (mode_q == MODE_STEEP_LEFT);
          end
        end
      end
      ST_DIFF: begin
        dx_q  <= $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
        ady_q <= y1_q - y0_q;
      end
      ST_WALK: begin
        h_q <= step_h;
        if (mode_q != MODE_SHALLOW) begin
          res_l_q <= edge_x_q;
          res_r_q <= edge_x_q;
        end else if (left_q) begin
          res_l_q <= h_p1[C-1:0];
          res_r_q <= edge_x_q;
        end else begin
          res_l_q <= edge_x_q;
          res_r_q <= h_m1[C-1:0];
        end
      end
      default: ;
    endcase
    if (out_load) begin
      mo_user_q <= res_valid_q;
      mo_l_q    <= res_l_q;
      mo_r_q    <= res_r_q;
    end
  end

  assign m_axis_tvalid = mo_valid_q;
  assign m_axis_tuser  = mo_user_q;
  assign m_axis_tdata  = OutW'({mo_r_q, mo_l_q});

`ifndef SYNTHESIS
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (mo_l_q <= mo_r_q))
    else $error("span left end beyond right end");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (mo_l_q == '0 && mo_r_q == '0))
    else $error("not-valid result carries nonzero x");

  a_walk_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> active_q)
    else $error("walk on an ended line");

  a_steep_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK && mode_q != MODE_SHALLOW) |=> (state_q == ST_DONE))
    else $error("steep line took more than one step");
`endif

endmodule

// ===== src/sbs_step.sv =====
// One Bresenham step: error-term update and x step, shared by all walk cycles.
// Depends on sbs_pkg.
module sbs_step import sbs_pkg::*; #(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic signed [COORD_BITS+2:0] err_i,
  input  logic signed [COORD_BITS+2:0] diag_i,
  input  logic        [COORD_BITS:0]   str_i,
  input  logic signed [COORD_BITS+1:0] h_i,
  input  step_ctl_t                    ctl_i,
  output logic signed [COORD_BITS+2:0] err_o,
  output logic signed [COORD_BITS+1:0] h_o,
  output logic                         pos_o
);

  localparam int unsigned EW = COORD_BITS + 3;
  localparam int unsigned XW = COORD_BITS + 2;

  logic signed [EW-1:0] addend;
  logic                 move;

  assign pos_o  = (err_i > $signed(EW'(0)));
  assign addend = pos_o ? diag_i : $signed({2'b00, str_i});
  assign err_o  = err_i + addend;
  assign move   = ctl_i.always_move | pos_o;

  always_comb begin
    if (!move) begin
      h_o = h_i;
    end else if (ctl_i.left) begin
      h_o = h_i - $signed(XW'(1));
    end else begin
      h_o = h_i + $signed(XW'(1));
    end
  end

endmodule

// ===== bench/tb_scanline_bresenham_span.sv =====
// Self-checking bench for scanline_bresenham_span: drives start/next requests,
// predicts every span in-bench and checks each result in order.
// Depends on sbs_pkg and the scanline_bresenham_span RTL.
`timescale 1ns / 100ps

module tb_scanline_bresenham_span;
  import sbs_pkg::*;

  localparam int CW        = CoordBitsDef;
  localparam int CoordMax  = (1 << CW) - 1;
  localparam int InW       = ((4 * CW + 7) / 8) * 8;
  localparam int OutW      = ((2 * CW + 7) / 8) * 8;
  localparam int PhaseReqs = 145;
  localparam int StallLimit = 20000;
  localparam int TailCycles = 1100;

  typedef struct packed {
    cmd_e          cmd;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
  } line_req_t;

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] lx;
    logic [CW-1:0] rx;
  } span_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [InW-1:0]  s_axis_tdata = '0;
  logic            s_axis_tuser = 1'b0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [OutW-1:0] m_axis_tdata;
  logic            m_axis_tuser;

  line_req_t line_cmds[$];
  span_t     due_spans[$];
  line_req_t cur_req;
  int        pushed_cnt = 0;
  int        err_cnt = 0;
  int        quiet_cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  // line walker state
  mode_e     line_mode = MODE_SHALLOW;
  int        err_d = 0;
  int        diag_inc = 0;
  int        str_inc = 0;
  int        walk_x = 0;
  int        walk_lim = 0;
  bit        line_on = 1'b0;

  scanline_bresenham_span i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void setup_line(input line_req_t r);
    int x0, y0, x1, y1, dx, ady, adx;
    x0 = r.sx;
    y0 = r.sy;
    x1 = r.ex;
    y1 = r.ey;
    if (y0 > y1) begin
      x0 = r.ex;
      y0 = r.ey;
      x1 = r.sx;
      y1 = r.sy;
    end
    dx  = x1 - x0;
    ady = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    walk_x = x0;
    if (adx > ady) begin
      line_mode = MODE_SHALLOW;
      err_d     = 2 * ady - adx;
      diag_inc  = 2 * (ady - adx);
      str_inc   = 2 * ady;
      walk_lim  = x1;
    end else begin
      line_mode = (dx >= 0) ? MODE_STEEP_RIGHT : MODE_STEEP_LEFT;
      err_d     = 2 * adx - ady;
      diag_inc  = 2 * (adx - ady);
      str_inc   = 2 * adx;
      walk_lim  = ady;
    end
    line_on = 1'b1;
  endfunction

  // Advances the line model by one accepted request and queues its result.
  function automatic void walk_scanline(input line_req_t r);
    span_t s;
    int h, k, lx, rx;
    s = '0;
    if (r.cmd == CMD_START) begin
      setup_line(r);
    end else if (line_on) begin
      h = walk_x;
      k = walk_lim;
      if (line_mode == MODE_SHALLOW) begin
        if (h < k) begin
          lx = h;
          while (1) begin
            if (err_d > 0) begin
              err_d += diag_inc;
              h++;
              break;
            end
            err_d += str_inc;
            h++;
            if (h > k) break;
          end
          rx = h - 1;
          if (h > k) line_on = 1'b0;
        end else begin
          rx = h;
          while (1) begin
            if (err_d > 0) begin
              err_d += diag_inc;
              h--;
              break;
            end
            err_d += str_inc;
            h--;
            if (h < k) break;
          end
          lx = h + 1;
          if (h < k) line_on = 1'b0;
        end
      end else begin
        lx = h;
        rx = h;
        if (err_d > 0) begin
          h += (line_mode == MODE_STEEP_LEFT) ? -1 : 1;
          err_d += diag_inc;
        end else begin
          err_d += str_inc;
        end
        k--;
        walk_lim = k;
        if (k < 0) line_on = 1'b0;
      end
      walk_x = h & CoordMax;
      s.valid = 1'b1;
      s.lx = lx[CW-1:0];
      s.rx = rx[CW-1:0];
    end
    due_spans.push_back(s);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 40) $display("[%0t] span mismatch: %s", $time, msg);
  endtask

  task automatic push_req(input cmd_e cmd, input int sx, input int sy, input int ex,
                          input int ey);
    line_req_t r;
    r.cmd = cmd;
    r.sx = sx[CW-1:0];
    r.sy = sy[CW-1:0];
    r.ex = ex[CW-1:0];
    r.ey = ey[CW-1:0];
    line_cmds.push_back(r);
    pushed_cnt++;
  endtask

  task automatic add_line(input int x0, input int y0, input int x1, input int y1,
                          input int n);
    push_req(CMD_START, x0, y0, x1, y1);
    repeat (n) push_req(CMD_NEXT, $urandom_range(CoordMax), $urandom_range(CoordMax),
                        $urandom_range(CoordMax), $urandom_range(CoordMax));
  endtask

  function automatic int clip(input int v);
    return (v < 0) ? 0 : (v > CoordMax) ? CoordMax : v;
  endfunction

  task automatic add_random_line();
    int x0, y0, x1, y1, n, dy;
    bit partial;
    x0 = $urandom_range(CoordMax);
    y0 = $urandom_range(CoordMax);
    partial = 1'b0;
    case ($urandom_range(9))
      0: begin
        x1 = $urandom_range(CoordMax);
        y1 = y0 + int'($urandom_range(3)) - int'($urandom_range(3));
      end
      1: begin
        x1 = $urandom_range(CoordMax);
        y1 = $urandom_range(CoordMax);
        partial = 1'b1;
      end
      default: begin
        x1 = x0 + int'($urandom_range(120)) - 60;
        y1 = y0 + int'($urandom_range(20)) - 10;
      end
    endcase
    x1 = clip(x1);
    y1 = clip(y1);
    dy = (y1 > y0) ? y1 - y0 : y0 - y1;
    if (partial) begin
      n = $urandom_range(1, 4);
    end else begin
      n = dy + 1 + $urandom_range(2);
      if ($urandom_range(9) == 0) n = $urandom_range(n);
    end
    add_line(x0, y0, x1, y1, n);
  endtask

  task automatic wait_drained();
    while (line_cmds.size() != 0 || s_axis_tvalid || due_spans.size() != 0)
      @(negedge clk_i);
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) walk_scanline(cur_req);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (line_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = line_cmds.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.cmd;
          s_axis_tdata  <= {cur_req.ey, cur_req.ex, cur_req.sy, cur_req.sx};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    span_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (due_spans.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = due_spans.pop_front();
          if (m_axis_tuser !== want.valid)
            report_mismatch($sformatf("span_valid got %b want %b", m_axis_tuser, want.valid));
          if (m_axis_tdata[CW-1:0] !== want.lx)
            report_mismatch($sformatf("left_x got %0d want %0d",
                                      m_axis_tdata[CW-1:0], want.lx));
          if (m_axis_tdata[2*CW-1:CW] !== want.rx)
            report_mismatch($sformatf("right_x got %0d want %0d",
                                      m_axis_tdata[2*CW-1:CW], want.rx));
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("timeout: no handshake for %0d cycles", StallLimit);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int send_pct[4];
    int recv_pct[4];
    int target;
    send_pct = '{0, 57, 0, 17};
    recv_pct = '{0, 0, 57, 17};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // next before any line, then single point, full-width runs both ways,
    // swapped endpoints, steep left, diagonal cut off by a new start
    push_req(CMD_NEXT, CoordMax, CoordMax, CoordMax, CoordMax);
    add_line(5, 5, 5, 5, 2);
    add_line(0, 7, CoordMax, 7, 2);
    add_line(0, CoordMax, CoordMax, CoordMax - 2, 3);
    add_line(CoordMax, 0, CoordMax - 2, 3, 5);
    add_line(0, CoordMax - 3, 3, CoordMax, 2);
    add_line(CoordMax, 0, 0, 0, 1);
    push_req(CMD_NEXT, 0, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      target = pushed_cnt + PhaseReqs;
      while (pushed_cnt < target) begin
        if ($urandom_range(99) < 15)
          push_req(cmd_e'($urandom_range(1)), $urandom_range(CoordMax),
                   $urandom_range(CoordMax), $urandom_range(CoordMax),
                   $urandom_range(CoordMax));
        else
          add_random_line();
      end
      // sender holds off until every span of this phase is back
      wait_drained();
    end

    repeat (TailCycles) @(negedge clk_i);
    if (err_cnt == 0 && due_spans.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sbs_pkg.sv
src/sbs_step.sv
src/scanline_bresenham_span.sv
bench/tb_scanline_bresenham_span.sv
